>>> rtl/core/ddo_pkg.sv
`default_nettype none

package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANGLE_WIDTH  = 16;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);

    localparam int XY_W   = 34;
    localparam int Z_W    = 33;
    localparam int TRIG_W = 32;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 33;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [XY_W-1:0]   CORDIC_K = XY_W'(652032874);
    localparam logic signed [TRIG_W-1:0] ONE_Q30  = TRIG_W'(32'sd1 <<< 30);

    localparam logic [7:0] REG_HEADING_GAIN  = 8'd0;
    localparam logic [7:0] REG_START_HEADING = 8'd1;
    localparam logic [7:0] REG_START_X       = 8'd2;
    localparam logic [7:0] REG_START_Y       = 8'd3;

    localparam logic [31:0] HEADING_GAIN_RST = 32'd10680707;

    typedef logic signed [ANGLE_WIDTH-1:0] angle_t;

    typedef struct packed {
        logic                     done;
        logic signed [TRIG_W-1:0] cos_v;
        logic signed [TRIG_W-1:0] sin_v;
    } cordic_res_t;

    // arctangent of 2^-i in units of 2^32 per turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ddo_mul.sv
`default_nettype none

module ddo_mul (
    input  wire logic                                  clk,
    input  wire logic signed [ddo_pkg::MUL_A_W-1:0]    a,
    input  wire logic signed [ddo_pkg::MUL_B_W-1:0]    b,
    output logic signed [ddo_pkg::MUL_P_W-1:0]         p
);
    import ddo_pkg::*;

    logic signed [MUL_P_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_P_W'(a) * MUL_P_W'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

>>> rtl/core/ddo_cordic.sv
`default_nettype none

module ddo_cordic (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire ddo_pkg::angle_t angle,
    output ddo_pkg::cordic_res_t res
);
    import ddo_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_RUN, C_OUT} cstate_t;

    cstate_t                  state_reg, state_next;
    logic [STEP_W-1:0]        cnt_reg, cnt_next;
    logic signed [XY_W-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]    z_reg, z_next;
    logic                     flip_reg, flip_next;
    logic                     done_reg, done_next;
    logic signed [TRIG_W-1:0] cos_reg, cos_next, sin_reg, sin_next;

    logic [31:0]              z32;
    logic signed [Z_W-1:0]    z_in;
    logic signed [Z_W-1:0]    atan_v;
    logic signed [XY_W-1:0]   x_sh, y_sh, x_fin, y_fin;

    function automatic logic signed [TRIG_W-1:0] clamp_q30(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] hi;
        logic signed [TRIG_W-1:0] r;
        hi = XY_W'(ONE_Q30);
        if (v > hi)
            r = ONE_Q30;
        else if (v < -hi)
            r = -ONE_Q30;
        else
            r = TRIG_W'(v);
        return r;
    endfunction

    assign z32    = {angle, {(32 - ANGLE_WIDTH){1'b0}}};
    assign z_in   = Z_W'($signed(z32));
    assign atan_v = Z_W'($signed({1'b0, atan_turn(5'(cnt_reg))}));
    assign x_sh   = x_reg >>> cnt_reg;
    assign y_sh   = y_reg >>> cnt_reg;
    assign x_fin  = flip_reg ? -x_reg : x_reg;
    assign y_fin  = flip_reg ? -y_reg : y_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        flip_next  = flip_reg;
        done_next  = 1'b0;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    // fold angles beyond a quarter turn by a half turn
                    x_next   = CORDIC_K;
                    y_next   = '0;
                    cnt_next = '0;
                    if (z_in > Z_W'(ONE_Q30))
                    begin
                        z_next    = z_in - (Z_W'(1) <<< 31);
                        flip_next = 1'b1;
                    end
                    else if (z_in < -Z_W'(ONE_Q30))
                    begin
                        z_next    = z_in + (Z_W'(1) <<< 31);
                        flip_next = 1'b1;
                    end
                    else
                    begin
                        z_next    = z_in;
                        flip_next = 1'b0;
                    end
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - y_sh;
                    y_next = y_reg + x_sh;
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + y_sh;
                    y_next = y_reg - x_sh;
                    z_next = z_reg + atan_v;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(CORDIC_STEPS - 1))
                    state_next = C_OUT;
            end
            C_OUT:
            begin
                cos_next   = clamp_q30(x_fin);
                sin_next   = clamp_q30(y_fin);
                done_next  = 1'b1;
                state_next = C_IDLE;
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
            flip_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
            flip_reg  <= flip_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
        cos_reg <= cos_next;
        sin_reg <= sin_next;
    end

    assign res.done  = done_reg;
    assign res.cos_v = cos_reg;
    assign res.sin_v = sin_reg;

endmodule

`default_nettype wire

>>> rtl/core/differential_drive_odometry.sv
// one item at a time: s_tready is low from input transfer until the result is
// loaded into the output register; the iterative cordic runs one step per cycle
// in mode 0, and the one shared multiplier is used three times per mode 0 item
// (heading, x and y deltas) and once per mode 1 item (heading)
// reset: async active low, pose and previous distances cleared, registers to defaults
`default_nettype none

module differential_drive_odometry (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // left_distance, right_distance
    input  wire logic        s_tuser,   // mode
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // x_position, y_position, heading
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import ddo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_HEAD, S_ANGLE, S_ROTATE, S_MUL_X, S_MUL_Y, S_ACC_Y, S_FINISH
    } state_t;

    state_t             state_reg, state_next;
    logic [31:0]        gain_reg;
    logic signed [15:0] start_heading_reg;
    logic signed [31:0] start_x_reg, start_y_reg;
    logic signed [31:0] pose_x_reg, pose_x_next, pose_y_reg, pose_y_next;
    logic signed [31:0] prev_l_reg, prev_l_next, prev_r_reg, prev_r_next;
    logic signed [31:0] l_reg, l_next, r_reg, r_next;
    logic               mode_reg, mode_next;
    logic signed [MUL_A_W-1:0] diff_reg, diff_next, sum_reg, sum_next;
    angle_t             ang_reg, ang_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [79:0]        m_tdata_reg, m_tdata_next;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;
    cordic_res_t        cres;
    logic               cordic_start;

    logic signed [31:0] in_l, in_r;
    logic signed [39:0] sh40, a40;
    angle_t             start_al, ang_calc;
    logic signed [15:0] heading_out;
    logic signed [MUL_P_W-1:0] p_rnd;
    logic signed [36:0] pose_sel, pose_sum;
    logic signed [31:0] pose_sat;

    assign in_l = $signed(s_tdata[31:0]);
    assign in_r = $signed(s_tdata[63:32]);

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // start heading aligned to the internal angle width, floor for narrowing
    assign sh40     = 40'(start_heading_reg) <<< 24;
    assign start_al = ANGLE_WIDTH'(sh40 >>> (40 - ANGLE_WIDTH));
    assign ang_calc = angle_t'(mul_p[24 +: ANGLE_WIDTH]) + start_al;

    assign a40         = 40'(ang_reg) <<< 16;
    assign heading_out = 16'(a40 >>> ANGLE_WIDTH);

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_HEAD:
            begin
                mul_a = diff_reg;
                mul_b = $signed({1'b0, gain_reg});
            end
            S_MUL_Y:
            begin
                mul_a = sum_reg;
                mul_b = MUL_B_W'(cres.sin_v);
            end
            default:
            begin
                mul_a = sum_reg;
                mul_b = MUL_B_W'(cres.cos_v);
            end
        endcase
    end

    ddo_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign cordic_start = (state_reg == S_ANGLE) && !mode_reg;

    ddo_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .angle (ang_calc),
        .res   (cres)
    );

    // rounded delta added to the pose axis being updated, then saturated
    assign p_rnd    = mul_p + (MUL_P_W'(1) <<< 30);
    assign pose_sel = (state_reg == S_MUL_Y) ? 37'(pose_x_reg) : 37'(pose_y_reg);
    assign pose_sum = pose_sel + 37'($signed(p_rnd[MUL_P_W-1:31]));

    always_comb
    begin
        if (pose_sum > 37'sd2147483647)
            pose_sat = 32'sh7fffffff;
        else if (pose_sum < -37'sd2147483648)
            pose_sat = 32'sh80000000;
        else
            pose_sat = 32'(pose_sum);
    end

    always_comb
    begin
        state_next    = state_reg;
        pose_x_next   = pose_x_reg;
        pose_y_next   = pose_y_reg;
        prev_l_next   = prev_l_reg;
        prev_r_next   = prev_r_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        mode_next     = mode_reg;
        diff_next     = diff_reg;
        sum_next      = sum_reg;
        ang_next      = ang_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    mode_next  = s_tuser;
                    l_next     = in_l;
                    r_next     = in_r;
                    diff_next  = MUL_A_W'(in_r) - MUL_A_W'(in_l);
                    sum_next   = (MUL_A_W'(in_l) - MUL_A_W'(prev_l_reg))
                               + (MUL_A_W'(in_r) - MUL_A_W'(prev_r_reg));
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
                state_next = S_ANGLE;
            S_ANGLE:
            begin
                ang_next = ang_calc;
                if (mode_reg)
                begin
                    pose_x_next = start_x_reg;
                    pose_y_next = start_y_reg;
                    state_next  = S_FINISH;
                end
                else
                    state_next = S_ROTATE;
            end
            S_ROTATE:
            begin
                if (cres.done)
                    state_next = S_MUL_X;
            end
            S_MUL_X:
                state_next = S_MUL_Y;
            S_MUL_Y:
            begin
                pose_x_next = pose_sat;
                state_next  = S_ACC_Y;
            end
            S_ACC_Y:
            begin
                pose_y_next = pose_sat;
                state_next  = S_FINISH;
            end
            S_FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {heading_out, pose_y_reg, pose_x_reg};
                    prev_l_next   = l_reg;
                    prev_r_next   = r_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            gain_reg          <= HEADING_GAIN_RST;
            start_heading_reg <= '0;
            start_x_reg       <= '0;
            start_y_reg       <= '0;
            pose_x_reg        <= '0;
            pose_y_reg        <= '0;
            prev_l_reg        <= '0;
            prev_r_reg        <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pose_x_reg   <= pose_x_next;
            pose_y_reg   <= pose_y_next;
            prev_l_reg   <= prev_l_next;
            prev_r_reg   <= prev_r_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_HEADING_GAIN:  gain_reg          <= cfg_data;
                    REG_START_HEADING: start_heading_reg <= $signed(cfg_data[15:0]);
                    REG_START_X:       start_x_reg       <= $signed(cfg_data);
                    REG_START_Y:       start_y_reg       <= $signed(cfg_data);
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        l_reg       <= l_next;
        r_reg       <= r_next;
        mode_reg    <= mode_next;
        diff_reg    <= diff_next;
        sum_reg     <= sum_next;
        ang_reg     <= ang_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_cordic_done_in_rotate : assert property (@(posedge clk) disable iff (!rst_n)
        cres.done |-> state_reg == S_ROTATE)
        else $error("cordic result outside rotate phase");

    a_result_from_finish : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_FINISH))
        else $error("result raised outside finish phase");

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready while an item is in progress");

    a_cordic_only_mode0 : assert property (@(posedge clk) disable iff (!rst_n)
        cordic_start |-> !mode_reg && state_reg == S_ANGLE)
        else $error("rotation started for a load item");

endmodule

`default_nettype wire
